FILE: hdl/rcsc_pkg.sv
// Package: constants, codes, state and control types of the style cache.
`timescale 1ns / 1ps
package rcsc_pkg;

	localparam int ROWS            = 16;
	localparam int WAYS_PER_SCREEN = 8;
	localparam int SCREENS         = 2;
	localparam int CONTEXTS        = 128;
	localparam int WAYS            = WAYS_PER_SCREEN * SCREENS;
	localparam int TOTAL           = ROWS * WAYS;
	localparam int ENT_W           = $clog2(TOTAL);
	localparam int CTX_W           = $clog2(CONTEXTS);
	localparam int WAY_W           = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W           = $clog2(ROWS);
	localparam int CNT_W           = 16;
	localparam int PIX_W           = 32;
	localparam int STYLE_W         = 13;
	localparam int FONT_W          = 29;

	localparam logic [1:0] CMD_FIND    = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_PURGE   = 2'd2;

	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_FILLED    = 3'd1;
	localparam logic [2:0] ST_REPLACED  = 3'd2;
	localparam logic [2:0] ST_CFAULT    = 3'd3;
	localparam logic [2:0] ST_XFAULT    = 3'd4;
	localparam logic [2:0] ST_DONE      = 3'd5;
	localparam logic [2:0] ST_UNDERFLOW = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE, S_F_SLOT, S_F_ENT, S_F_CTX, S_F_CMP, S_F_SWAP,
		S_K_SCAN, S_R_RD, S_R_CHK, S_P_RUN, S_P_TAIL
	} state_t;

	typedef enum logic [2:0] {
		RK_HIT, RK_FILL, RK_REPL, RK_CFAULT, RK_XFAULT, RK_DONE, RK_REL_OK, RK_REL_UF
	} res_kind_t;

	typedef enum logic [1:0] {
		SRC_SLOT, SRC_ID, SRC_PURGE
	} ent_src_t;

	typedef struct packed {
		logic      load;
		logic      slot_rd;
		logic      e_latch;
		logic      ent_rd;
		ent_src_t  ent_src;
		logic      ctx_rd;
		logic      next_way;
		logic      hit_wr;
		logic      swap_wr;
		logic      repl_wr;
		logic      k_inc;
		logic      fill_wr;
		logic      rel_wr;
		logic      purge_rd;
		logic      res_load;
		res_kind_t res_kind;
	} dp_ctrl_t;

	typedef struct packed {
		logic ent_valid;
		logic match;
		logic way_last;
		logic swap;
		logic repl_ok;
		logic k_ok;
		logic k_last;
		logic rel_zero;
		logic p_last;
	} dp_stat_t;

endpackage

FILE: hdl/rcsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rcsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/rcsc_dp.sv
// Datapath: entry and context stores, probe registers, counters and result register.
`timescale 1ns / 1ps
module rcsc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  rcsc_pkg::dp_ctrl_t ctl,
	output rcsc_pkg::dp_stat_t stat,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [31:0]        pixel,
	input  logic               screen,
	input  logic [3:0]         draw_function,
	input  logic               clip_mode,
	input  logic [7:0]         pen_width,
	input  logic [28:0]        font_id,
	input  logic [7:0]         item_id,
	output logic               done,
	output logic [2:0]         status,
	output logic [7:0]         entry,
	output logic [6:0]         context_res,
	output logic               reprogram_all,
	output logic               reprogram_font
);
	import rcsc_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// captured transaction
	logic [ROW_W-1:0]   row_q;
	logic [PIX_W-1:0]   pix_q;
	logic               scr_q;
	logic [STYLE_W-1:0] style_q;
	logic [FONT_W-1:0]  font_q;
	logic [ENT_W-1:0]   id_q;

	// probe state
	logic [WAY_W-1:0] way_q;
	logic [ENT_W-1:0] e_q, prev_e_q;
	logic [CNT_W-1:0] prev_hit_q, rc_q, hit_q;
	logic [CTX_W-1:0] c_q, k_q;
	logic [ENT_W-1:0] p_q, p_s1;
	logic             pv_s1;

	// per-entry and per-context flags
	logic [TOTAL-1:0]    valid_q;
	logic [TOTAL-1:0]    slot_wr_q;
	logic [CONTEXTS-1:0] created_q, in_use_q, ctx_scr_q;

	// memory ports
	logic             slot_we;
	logic [ENT_W-1:0] slot_waddr, slot_wdata, slot_raw, slot_ra_s1, slot_rd;
	logic [ENT_W-1:0] slot_cur, slot_prev;
	logic             ent_we_ctx, rc_we, hit_we;
	logic [ENT_W-1:0] ent_raddr, rc_waddr;
	logic [CTX_W-1:0] ectx_rd;
	logic [CNT_W-1:0] rc_rd, hit_rd, rc_wdata, hit_wdata;
	logic             ps_we, font_we;
	logic [CTX_W-1:0] ps_waddr, font_waddr;
	logic [FONT_W-1:0] font_rd;
	logic [STYLE_W+PIX_W-1:0] ps_rd;

	logic [CNT_W-1:0] rc_inc, hit_inc;
	logic             scr_c, font_chg, purge_hit;

	assign slot_cur  = ENT_W'(int'(row_q) * WAYS + int'(way_q));
	assign slot_prev = ENT_W'(slot_cur - 1'b1);
	assign rc_inc    = (rc_q == CNT_MAX) ? rc_q : CNT_W'(rc_q + 1'b1);
	assign hit_inc   = (hit_q == CNT_MAX) ? hit_q : CNT_W'(hit_q + 1'b1);
	assign scr_c     = ctx_scr_q[c_q];
	assign font_chg  = (font_q != '0) && (font_q != font_rd);
	assign purge_hit = pv_s1 && valid_q[p_s1] && (rc_rd == '0);

	// capture the transaction
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			row_q   <= ROW_W'((red ^ green ^ blue) % ROWS);
			pix_q   <= pixel;
			scr_q   <= screen;
			style_q <= {pen_width, clip_mode, draw_function};
			font_q  <= font_id;
			id_q    <= ENT_W'(item_id);
		end
	end

	// advance probe, scan and purge counters
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			way_q      <= '0;
			p_q        <= '0;
			prev_hit_q <= '0;
		end else begin
			if (ctl.next_way) begin
				way_q      <= WAY_W'(way_q + 1'b1);
				prev_e_q   <= e_q;
				prev_hit_q <= hit_q;
			end
			if (ctl.purge_rd) begin
				p_q <= ENT_W'(p_q + 1'b1);
			end
		end
		if (ctl.e_latch) begin
			e_q <= ent_raddr;
		end
		if (ctl.ctx_rd) begin
			c_q   <= ectx_rd;
			rc_q  <= rc_rd;
			hit_q <= hit_rd;
			k_q   <= '0;
		end else if (ctl.k_inc) begin
			k_q <= CTX_W'(k_q + 1'b1);
		end
		if (ctl.slot_rd) begin
			slot_ra_s1 <= slot_cur;
		end
		p_s1 <= p_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= ctl.purge_rd;
		end
	end

	// update entry and context flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			slot_wr_q <= '0;
			created_q <= '0;
			in_use_q  <= '0;
			ctx_scr_q <= '0;
		end else begin
			if (slot_we) begin
				slot_wr_q[slot_waddr] <= 1'b1;
			end
			if (ctl.fill_wr) begin
				valid_q[e_q]   <= 1'b1;
				created_q[k_q] <= 1'b1;
				in_use_q[k_q]  <= 1'b1;
				ctx_scr_q[k_q] <= scr_q;
			end
			if (ctl.repl_wr) begin
				in_use_q[c_q]  <= 1'b1;
				ctx_scr_q[c_q] <= scr_q;
			end
			if (purge_hit) begin
				valid_q[p_s1]     <= 1'b0;
				in_use_q[ectx_rd] <= 1'b0;
			end
		end
	end

	// slot order store; unwritten slots read as their own index
	always_comb begin
		slot_we    = ctl.hit_wr && stat.swap;
		slot_waddr = slot_cur;
		slot_wdata = prev_e_q;
		if (ctl.swap_wr) begin
			slot_we    = 1'b1;
			slot_waddr = slot_prev;
			slot_wdata = e_q;
		end
	end

	rcsc_ram #(.WIDTH(ENT_W), .DEPTH(TOTAL)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(ctl.slot_rd), .raddr(slot_cur), .rdata(slot_raw)
	);

	assign slot_rd = slot_wr_q[slot_ra_s1] ? slot_raw : slot_ra_s1;

	// entry stores
	always_comb begin
		unique case (ctl.ent_src)
			SRC_SLOT:  ent_raddr = slot_rd;
			SRC_ID:    ent_raddr = id_q;
			SRC_PURGE: ent_raddr = p_q;
			default:   ent_raddr = slot_rd;
		endcase
	end

	always_comb begin
		ent_we_ctx = ctl.fill_wr;
		rc_we      = ctl.hit_wr || ctl.fill_wr || ctl.repl_wr || ctl.rel_wr;
		hit_we     = ctl.hit_wr || ctl.fill_wr || ctl.repl_wr;
		rc_waddr   = ctl.rel_wr ? id_q : e_q;
		rc_wdata   = CNT_W'(1);
		hit_wdata  = CNT_W'(1);
		if (ctl.hit_wr) begin
			rc_wdata  = rc_inc;
			hit_wdata = hit_inc;
		end else if (ctl.rel_wr) begin
			rc_wdata = CNT_W'(rc_rd - 1'b1);
		end
	end

	rcsc_ram #(.WIDTH(CTX_W), .DEPTH(TOTAL)) u_ectx (
		.clk(clk), .we(ent_we_ctx), .waddr(e_q), .wdata(k_q),
		.re(ctl.ent_rd), .raddr(ent_raddr), .rdata(ectx_rd)
	);

	rcsc_ram #(.WIDTH(CNT_W), .DEPTH(TOTAL)) u_rc (
		.clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
		.re(ctl.ent_rd), .raddr(ent_raddr), .rdata(rc_rd)
	);

	rcsc_ram #(.WIDTH(CNT_W), .DEPTH(TOTAL)) u_hit (
		.clk(clk), .we(hit_we), .waddr(e_q), .wdata(hit_wdata),
		.re(ctl.ent_rd), .raddr(ent_raddr), .rdata(hit_rd)
	);

	// context pixel, style and font stores
	assign ps_we      = ctl.fill_wr || ctl.repl_wr;
	assign ps_waddr   = ctl.fill_wr ? k_q : c_q;
	assign font_we    = ps_we || (ctl.hit_wr && font_chg);
	assign font_waddr = ps_waddr;

	rcsc_ram #(.WIDTH(STYLE_W + PIX_W), .DEPTH(CONTEXTS)) u_ps (
		.clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata({style_q, pix_q}),
		.re(ctl.ctx_rd), .raddr(ectx_rd), .rdata(ps_rd)
	);

	rcsc_ram #(.WIDTH(FONT_W), .DEPTH(CONTEXTS)) u_font (
		.clk(clk), .we(font_we), .waddr(font_waddr), .wdata(font_q),
		.re(ctl.ctx_rd), .raddr(ectx_rd), .rdata(font_rd)
	);

	// status toward the controller
	always_comb begin
		stat.ent_valid = valid_q[e_q];
		stat.match     = (ps_rd == {style_q, pix_q}) && (scr_c == scr_q);
		stat.way_last  = (way_q == WAY_W'(WAYS - 1));
		stat.swap      = (way_q != '0) && (hit_inc > prev_hit_q);
		stat.repl_ok   = (rc_q == '0) && (scr_c == scr_q);
		stat.k_ok      = !created_q[k_q] || (!in_use_q[k_q] && (ctx_scr_q[k_q] == scr_q));
		stat.k_last    = (k_q == CTX_W'(CONTEXTS - 1));
		stat.rel_zero  = !valid_q[e_q] || (rc_rd == '0);
		stat.p_last    = (p_q == ENT_W'(TOTAL - 1));
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			reprogram_all  <= 1'b0;
			reprogram_font <= 1'b0;
			entry          <= 8'(e_q);
			context_res    <= '0;
			case (ctl.res_kind) inside
				RK_HIT: begin
					status         <= ST_HIT;
					context_res    <= 7'(c_q);
					reprogram_font <= font_chg;
				end
				RK_FILL: begin
					status        <= ST_FILLED;
					context_res   <= 7'(k_q);
					reprogram_all <= 1'b1;
				end
				RK_REPL: begin
					status        <= ST_REPLACED;
					context_res   <= 7'(c_q);
					reprogram_all <= 1'b1;
				end
				RK_CFAULT: begin
					status      <= ST_CFAULT;
					context_res <= 7'(c_q);
				end
				RK_XFAULT: begin
					status <= ST_XFAULT;
				end
				RK_REL_OK, RK_REL_UF: begin
					status      <= (ctl.res_kind == RK_REL_OK) ? ST_DONE : ST_UNDERFLOW;
					entry       <= 8'(id_q);
					context_res <= valid_q[e_q] ? 7'(ectx_rd) : 7'd0;
				end
				default: begin
					status <= ST_DONE;
					entry  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.res_load;
		end
	end

	// checks on the store updates
	a_fill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fill_wr |-> !valid_q[e_q]) else $error("fill of a valid entry");
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.hit_wr |-> valid_q[e_q]) else $error("hit on an invalid entry");
	a_rel_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rel_wr |-> !stat.rel_zero) else $error("release below zero");

endmodule

FILE: hdl/rcsc_ctrl.sv
// Controller: sequences find, release and purge transactions over the datapath.
`timescale 1ns / 1ps
module rcsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         cmd,
	output logic               busy,
	input  rcsc_pkg::dp_stat_t stat,
	output rcsc_pkg::dp_ctrl_t ctl
);
	import rcsc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd)
						CMD_FIND:    state_d = S_F_SLOT;
						CMD_RELEASE: state_d = S_R_RD;
						CMD_PURGE:   state_d = S_P_RUN;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_F_SLOT: state_d = S_F_ENT;
			S_F_ENT:  state_d = S_F_CTX;
			S_F_CTX:  state_d = stat.ent_valid ? S_F_CMP : S_K_SCAN;
			S_F_CMP: begin
				if (stat.match) begin
					state_d = stat.swap ? S_F_SWAP : S_IDLE;
				end else if (stat.way_last) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_F_SLOT;
				end
			end
			S_F_SWAP: state_d = S_IDLE;
			S_K_SCAN: begin
				if (stat.k_ok || stat.k_last) begin
					state_d = S_IDLE;
				end
			end
			S_R_RD:   state_d = S_R_CHK;
			S_R_CHK:  state_d = S_IDLE;
			S_P_RUN:  state_d = stat.p_last ? S_P_TAIL : S_P_RUN;
			S_P_TAIL: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctl          = '0;
		ctl.ent_src  = SRC_SLOT;
		ctl.res_kind = RK_DONE;
		unique case (state_q)
			S_IDLE: begin
				ctl.load = start;
				if (start && (cmd != CMD_FIND) && (cmd != CMD_RELEASE)
					&& (cmd != CMD_PURGE)) begin
					ctl.res_load = 1'b1;
				end
			end
			S_F_SLOT: ctl.slot_rd = 1'b1;
			S_F_ENT: begin
				ctl.e_latch = 1'b1;
				ctl.ent_rd  = 1'b1;
			end
			S_F_CTX: ctl.ctx_rd = 1'b1;
			S_F_CMP: begin
				if (stat.match) begin
					ctl.hit_wr = 1'b1;
					if (!stat.swap) begin
						ctl.res_load = 1'b1;
						ctl.res_kind = RK_HIT;
					end
				end else if (stat.way_last) begin
					ctl.res_load = 1'b1;
					ctl.repl_wr  = stat.repl_ok;
					ctl.res_kind = stat.repl_ok ? RK_REPL : RK_CFAULT;
				end else begin
					ctl.next_way = 1'b1;
				end
			end
			S_F_SWAP: begin
				ctl.swap_wr  = 1'b1;
				ctl.res_load = 1'b1;
				ctl.res_kind = RK_HIT;
			end
			S_K_SCAN: begin
				if (stat.k_ok) begin
					ctl.fill_wr  = 1'b1;
					ctl.res_load = 1'b1;
					ctl.res_kind = RK_FILL;
				end else if (stat.k_last) begin
					ctl.res_load = 1'b1;
					ctl.res_kind = RK_XFAULT;
				end else begin
					ctl.k_inc = 1'b1;
				end
			end
			S_R_RD: begin
				ctl.e_latch = 1'b1;
				ctl.ent_rd  = 1'b1;
				ctl.ent_src = SRC_ID;
			end
			S_R_CHK: begin
				ctl.res_load = 1'b1;
				ctl.rel_wr   = !stat.rel_zero;
				ctl.res_kind = stat.rel_zero ? RK_REL_UF : RK_REL_OK;
			end
			S_P_RUN: begin
				ctl.ent_rd   = 1'b1;
				ctl.ent_src  = SRC_PURGE;
				ctl.purge_rd = 1'b1;
			end
			S_P_TAIL: ctl.res_load = 1'b1;
			default: ;
		endcase
	end

	// sequencing checks
	a_leave_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && state_d == S_IDLE) |-> ctl.res_load)
		else $error("transaction ended without a result");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.hit_wr, ctl.swap_wr, ctl.repl_wr, ctl.fill_wr, ctl.rel_wr}))
		else $error("conflicting store writes");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.res_load |=> !busy) else $error("result issued mid transaction");

endmodule

FILE: hdl/refcounted_style_cache_unit.sv
// Find probes the ways of the row in order (up to 16 ways): slot read, entry read,
// context read, compare. A hit that promotes the entry adds a swap step; an empty way
// scans the pool contexts (up to 128) for a free one. Release reads, then checks; purge
// walks all 256 entries, one entry per cycle through the entry stores, then a tail step;
// other commands answer from idle. done rises in the cycle busy drops and the next
// transaction may start in that cycle; one transaction at a time, the receiver cannot
// stall. Reset (arst_n low) empties the cache at once: no clearing pass is needed.
`timescale 1ns / 1ps
module refcounted_style_cache_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [31:0] pixel,
	input  logic        screen,
	input  logic [3:0]  draw_function,
	input  logic        clip_mode,
	input  logic [7:0]  pen_width,
	input  logic [28:0] font_id,
	input  logic [7:0]  item_id,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  entry,
	output logic [6:0]  context_res,
	output logic        reprogram_all,
	output logic        reprogram_font
);
	import rcsc_pkg::*;

	dp_ctrl_t ctl;
	dp_stat_t stat;

	rcsc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .stat(stat), .ctl(ctl)
	);

	rcsc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(stat),
		.red(red), .green(green), .blue(blue), .pixel(pixel), .screen(screen),
		.draw_function(draw_function), .clip_mode(clip_mode),
		.pen_width(pen_width), .font_id(font_id), .item_id(item_id),
		.done(done), .status(status), .entry(entry), .context_res(context_res),
		.reprogram_all(reprogram_all), .reprogram_font(reprogram_font)
	);

endmodule

FILE: tb/sv/rcsc_checker.sv
// Checker: predicts style cache results from accepted transactions and compares them.
`timescale 1ns / 1ps
module rcsc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  cmd,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [31:0] pixel,
	input  logic        screen,
	input  logic [3:0]  draw_function,
	input  logic        clip_mode,
	input  logic [7:0]  pen_width,
	input  logic [28:0] font_id,
	input  logic [7:0]  item_id,
	input  logic        done,
	input  logic [2:0]  status,
	input  logic [7:0]  entry,
	input  logic [6:0]  context_res,
	input  logic        reprogram_all,
	input  logic        reprogram_font,
	output int          failures,
	output int          pending
);
	import rcsc_pkg::*;

	typedef struct packed {
		logic [2:0] st;
		logic [7:0] ent;
		logic [6:0] ctx;
		logic       all;
		logic       fnt;
	} cache_answer_t;

	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	// shadow copy of the cache
	logic [ENT_W-1:0]   slot_map   [TOTAL];
	logic [CTX_W-1:0]   ent_ctx    [TOTAL];
	logic               ent_live   [TOTAL];
	logic [CNT_W-1:0]   ent_refs   [TOTAL];
	logic [CNT_W-1:0]   ent_hits   [TOTAL];
	logic               ctx_made   [CONTEXTS];
	logic               ctx_busy   [CONTEXTS];
	logic               ctx_scr    [CONTEXTS];
	logic [PIX_W-1:0]   ctx_pix    [CONTEXTS];
	logic [STYLE_W-1:0] ctx_sty    [CONTEXTS];
	logic [FONT_W-1:0]  ctx_fnt    [CONTEXTS];

	cache_answer_t answers_q[$];

	function automatic void claim_ctx(int c, logic scr, logic [PIX_W-1:0] pix,
			logic [STYLE_W-1:0] sty, logic [FONT_W-1:0] fnt);
		ctx_pix[c]  = pix;
		ctx_sty[c]  = sty;
		ctx_fnt[c]  = fnt;
		ctx_scr[c]  = scr;
		ctx_busy[c] = 1'b1;
	endfunction

	function automatic cache_answer_t lookup_style(logic [7:0] key, logic [PIX_W-1:0] pix,
			logic scr, logic [STYLE_W-1:0] sty, logic [FONT_W-1:0] fnt);
		int base;
		int slot;
		int e;
		int c;
		int p;
		logic fchg;
		base = (key % ROWS) * WAYS;
		for (int i = 0; i < WAYS; i++) begin
			slot = base + i;
			e = slot_map[slot];
			// empty way: take a pool context of this screen
			if (!ent_live[e]) begin
				for (int k = 0; k < CONTEXTS; k++) begin
					if (!ctx_made[k]) begin
						ctx_made[k] = 1'b1;
						ctx_busy[k] = 1'b0;
						ctx_scr[k]  = scr;
					end
					if (!ctx_busy[k] && ctx_scr[k] == scr) begin
						claim_ctx(k, scr, pix, sty, fnt);
						ent_live[e] = 1'b1;
						ent_ctx[e]  = CTX_W'(k);
						ent_refs[e] = CNT_W'(1);
						ent_hits[e] = CNT_W'(1);
						return '{ST_FILLED, 8'(e), 7'(k), 1'b1, 1'b0};
					end
				end
				return '{ST_XFAULT, 8'(e), 7'd0, 1'b0, 1'b0};
			end
			c = ent_ctx[e];
			// hit: bump counts, maybe promote one slot
			if (ctx_pix[c] == pix && ctx_sty[c] == sty && ctx_scr[c] == scr) begin
				fchg = 1'b0;
				if (fnt != 0 && fnt != ctx_fnt[c]) begin
					ctx_fnt[c] = fnt;
					fchg = 1'b1;
				end
				if (ent_refs[e] != CNT_SAT) ent_refs[e]++;
				if (ent_hits[e] != CNT_SAT) ent_hits[e]++;
				if (i > 0) begin
					p = slot_map[slot-1];
					if (ent_hits[e] > ent_hits[p]) begin
						slot_map[slot]   = ENT_W'(p);
						slot_map[slot-1] = ENT_W'(e);
					end
				end
				return '{ST_HIT, 8'(e), 7'(c), 1'b0, fchg};
			end
			// full row: reuse the last way if idle and same screen
			if (i == WAYS - 1) begin
				if (ent_refs[e] == 0 && ctx_scr[c] == scr) begin
					claim_ctx(c, scr, pix, sty, fnt);
					ent_refs[e] = CNT_W'(1);
					ent_hits[e] = CNT_W'(1);
					return '{ST_REPLACED, 8'(e), 7'(c), 1'b1, 1'b0};
				end
				return '{ST_CFAULT, 8'(e), 7'(c), 1'b0, 1'b0};
			end
		end
		return '{ST_CFAULT, 8'd0, 7'd0, 1'b0, 1'b0};
	endfunction

	function automatic cache_answer_t run_command();
		int e;
		logic [6:0] c;
		case (cmd)
			CMD_FIND:
				return lookup_style(red ^ green ^ blue, pixel, screen,
					{pen_width, clip_mode, draw_function}, font_id);
			CMD_RELEASE: begin
				e = item_id;
				c = ent_live[e] ? ent_ctx[e] : 7'd0;
				if (ent_refs[e] == 0) return '{ST_UNDERFLOW, item_id, c, 1'b0, 1'b0};
				ent_refs[e]--;
				return '{ST_DONE, item_id, c, 1'b0, 1'b0};
			end
			CMD_PURGE: begin
				for (int i = 0; i < TOTAL; i++) begin
					e = slot_map[i];
					if (ent_live[e] && ent_refs[e] == 0) begin
						ctx_busy[ent_ctx[e]] = 1'b0;
						ent_live[e] = 1'b0;
						ent_ctx[e]  = '0;
					end
				end
				return '{ST_DONE, 8'd0, 7'd0, 1'b0, 1'b0};
			end
			default: return '{ST_DONE, 8'd0, 7'd0, 1'b0, 1'b0};
		endcase
	endfunction

	initial begin
		for (int i = 0; i < TOTAL; i++) begin
			slot_map[i] = ENT_W'(i);
			ent_ctx[i]  = '0;
			ent_live[i] = 1'b0;
			ent_refs[i] = '0;
			ent_hits[i] = '0;
		end
		for (int i = 0; i < CONTEXTS; i++) begin
			ctx_made[i] = 1'b0;
			ctx_busy[i] = 1'b0;
			ctx_scr[i]  = 1'b0;
			ctx_pix[i]  = '0;
			ctx_sty[i]  = '0;
			ctx_fnt[i]  = '0;
		end
		failures = 0;
		pending  = 0;
	end

	// compare each strobed result, then predict the newly accepted transaction
	always @(posedge clk) begin
		cache_answer_t want;
		cache_answer_t got;
		if (arst_n) begin
			if (done) begin
				got = '{status, entry, context_res, reprogram_all, reprogram_font};
				if (answers_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%t: result with nothing expected: %p", $realtime, got);
				end else begin
					want = answers_q.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display("%t: mismatch expected %p actual %p",
								$realtime, want, got);
					end
				end
			end
			if (start && !busy) answers_q.push_back(run_command());
			pending = answers_q.size();
		end
	end

endmodule

FILE: tb/sv/refcounted_style_cache_unit_test.sv
// Testbench top: stimulus for the style cache, checker hookup and verdict.
`timescale 1ns / 1ps
module refcounted_style_cache_unit_test;
	import rcsc_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  cmd = CMD_NOP;
	logic [7:0]  red = '0, green = '0, blue = '0;
	logic [31:0] pixel = '0;
	logic        screen = 1'b0;
	logic [3:0]  draw_function = '0;
	logic        clip_mode = 1'b0;
	logic [7:0]  pen_width = '0;
	logic [28:0] font_id = '0;
	logic [7:0]  item_id = '0;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  entry;
	logic [6:0]  context_res;
	logic        reprogram_all, reprogram_font;
	int          failures, pending;
	bit          calm;

	always #1 clk = ~clk;

	refcounted_style_cache_unit u_dut (.*);

	rcsc_checker u_checker (.*);

	// hold start until the transaction is taken, then maybe idle
	task automatic issue(logic [1:0] c, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [31:0] pix, logic scr, logic [3:0] fn, logic sw, logic [7:0] lw,
			logic [28:0] fnt, logic [7:0] id);
		int gap;
		int roll;
		cmd <= c; red <= r; green <= g; blue <= b; pixel <= pix; screen <= scr;
		draw_function <= fn; clip_mode <= sw; pen_width <= lw;
		font_id <= fnt; item_id <= id;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		roll = $urandom_range(0, 99);
		gap = calm ? 0 : (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 4)
			: $urandom_range(20, 300);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic find_style(logic [7:0] r, logic [31:0] pix, logic scr,
			logic [3:0] fn, logic [28:0] fnt);
		issue(CMD_FIND, r, 8'h00, 8'h00, pix, scr, fn, 1'b0, 8'd1, fnt, 8'd0);
	endtask

	// random find with a narrow palette so rows fill and hits recur
	task automatic random_find();
		logic [7:0] g;
		logic [7:0] r;
		logic [31:0] pix;
		g = 8'($urandom);
		r = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3) + 16 * $urandom_range(0, 15))
			: 8'($urandom);
		pix = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 23)) : 32'($urandom);
		issue(CMD_FIND, r, g, ($urandom_range(0, 9) < 8) ? g : 8'($urandom), pix,
			($urandom_range(0, 9) < 7) ? 1'b0 : 1'b1,
			($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1)),
			($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0,
			($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd1,
			($urandom_range(0, 2) == 0) ? 29'd0 : ($urandom_range(0, 3) == 0)
				? 29'($urandom) : 29'($urandom_range(1, 3)),
			8'($urandom));
	endtask

	initial begin
		int roll;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill, hit, font change, release, underflow, purge, unknown
		calm = 1'b1;
		find_style(8'h00, 32'h0, 1'b0, 4'h0, 29'd0);
		find_style(8'h00, 32'h0, 1'b0, 4'h0, 29'd0);
		find_style(8'h00, 32'h0, 1'b0, 4'h0, 29'h1FFF_FFFF);
		find_style(8'h00, 32'h0, 1'b0, 4'h0, 29'h1FFF_FFFF);
		issue(CMD_FIND, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 4'hF, 1'b1, 8'hFF,
			29'h1FFF_FFFF, 8'hFF);
		issue(CMD_RELEASE, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 4'h0, 1'b0, 8'h0, 29'd0, 8'd0);
		issue(CMD_RELEASE, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 4'h0, 1'b0, 8'h0, 29'd0, 8'd0);
		issue(CMD_RELEASE, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 4'h0, 1'b0, 8'h0, 29'd0, 8'd0);
		issue(CMD_RELEASE, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 4'h0, 1'b0, 8'h0, 29'd0, 8'd255);
		issue(CMD_PURGE, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 4'h0, 1'b0, 8'h0, 29'd0, 8'd0);
		issue(CMD_NOP, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0, 4'h0, 1'b0, 8'h0, 29'd0, 8'd0);
		// full row on row 0: 17 distinct styles, second screen, then replacement
		for (int i = 1; i <= 17; i++) find_style(8'h10, 32'(i), 1'b0, 4'h0, 29'd0);
		find_style(8'h00, 32'h100, 1'b1, 4'h0, 29'd0);
		for (int i = 0; i < 32; i++)
			issue(CMD_RELEASE, 8'h0, 8'h0, 8'h0, 32'h0, 1'b0, 4'h0, 1'b0, 8'h0, 29'd0, 8'(i));
		find_style(8'h00, 32'h200, 1'b0, 4'h0, 29'd0);

		// random: mostly finds on few rows, with releases and purges
		for (int n = 0; n < 520; n++) begin
			if (n % 60 == 0) calm = ($urandom_range(0, 2) == 0);
			if (n == 250) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			roll = $urandom_range(0, 99);
			if (roll < 62) random_find();
			else if (roll < 92)
				issue(CMD_RELEASE, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
					1'($urandom), 4'($urandom), 1'($urandom), 8'($urandom), 29'($urandom),
					($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63)));
			else if (roll < 97)
				issue(CMD_PURGE, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
					1'($urandom), 4'($urandom), 1'($urandom), 8'($urandom), 29'($urandom),
					8'($urandom));
			else
				issue(CMD_NOP, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
					1'($urandom), 4'($urandom), 1'($urandom), 8'($urandom), 29'($urandom),
					8'($urandom));
		end
		start <= 1'b0;

		// drain, then allow the longest operation to finish
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("refcounted_style_cache_unit verification clean");
		else
			$display("refcounted_style_cache_unit verification failed");
		$finish;
	end

	// run limit
	initial begin
		#4ms;
		$display("refcounted_style_cache_unit verification failed");
		$finish;
	end

endmodule
